### rtl/qxm_pkg.sv
package qxm_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MOTOR_IDX_W = 2;

  localparam int THR_W       = 12;
  localparam int CORR_W      = 17;
  localparam int CTRL_W      = 19;
  localparam int WEIGHT_W    = 16;
  localparam int TRIM_W      = 16;
  localparam int SCALE_W     = 17;
  localparam int QUOT_W      = 16;
  localparam int ROUND_SHIFT = 18;
  localparam int TOTAL_W     = 38;
  localparam int TGT_W       = 21;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIMS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW      = 3'd4;

  localparam logic [CFG_DATA_W-1:0] WEIGHTS_RST = 64'h4000_4000_4000_4000;
  localparam int PULSE_MIN_RST = 1000;
  localparam int PULSE_MAX_RST = 2000;
  localparam int SLEW_RST      = 50;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h1_0000;

  // bit i set: correction enters motor i negated
  localparam logic [MOTOR_COUNT-1:0] NEG_PITCH = 4'b1100;
  localparam logic [MOTOR_COUNT-1:0] NEG_ROLL  = 4'b1010;
  localparam logic [MOTOR_COUNT-1:0] NEG_YAW   = 4'b0110;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_CLAMP,
    ST_FIN
  } qxm_state_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } qxm_lane_ctl_t;

endpackage

### rtl/qxm_in_if.sv
interface qxm_in_if;
  import qxm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [THR_W-1:0]         throttle_us;
  logic signed [CORR_W-1:0] pitch_corr;
  logic signed [CORR_W-1:0] roll_corr;
  logic signed [CORR_W-1:0] yaw_corr;

  modport source(output valid, kind, throttle_us, pitch_corr, roll_corr, yaw_corr,
                 input ready);
  modport sink(input valid, kind, throttle_us, pitch_corr, roll_corr, yaw_corr,
               output ready);
endinterface

### rtl/qxm_out_if.sv
interface qxm_out_if #(parameter int PULSE_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] front_left_us;
  logic [PULSE_BITS-1:0] front_right_us;
  logic [PULSE_BITS-1:0] rear_left_us;
  logic [PULSE_BITS-1:0] rear_right_us;

  modport source(output valid, front_left_us, front_right_us, rear_left_us, rear_right_us,
                 input ready);
  modport sink(input valid, front_left_us, front_right_us, rear_left_us, rear_right_us,
               output ready);
endinterface

### rtl/qxm_cfg_if.sv
interface qxm_cfg_if;
  import qxm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/qxm_cfg_regs.sv
module qxm_cfg_regs #(
  parameter int PULSE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  qxm_cfg_if.sink                       cfg_wr,
  output logic [qxm_pkg::CFG_DATA_W-1:0] weights,
  output logic [qxm_pkg::CFG_DATA_W-1:0] trims,
  output logic [PULSE_BITS-1:0]          pulse_min,
  output logic [PULSE_BITS-1:0]          pulse_max,
  output logic [PULSE_BITS-1:0]          slew_step
);
  import qxm_pkg::*;

  logic [CFG_DATA_W-1:0] weights_r;
  logic [CFG_DATA_W-1:0] trims_r;
  logic [PULSE_BITS-1:0] pmin_r;
  logic [PULSE_BITS-1:0] pmax_r;
  logic [PULSE_BITS-1:0] slew_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r <= WEIGHTS_RST;
      trims_r   <= '0;
      pmin_r    <= PULSE_BITS'(PULSE_MIN_RST);
      pmax_r    <= PULSE_BITS'(PULSE_MAX_RST);
      slew_r    <= PULSE_BITS'(SLEW_RST);
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_WEIGHTS:   weights_r <= cfg_wr.data;
        REG_TRIMS:     trims_r   <= cfg_wr.data;
        REG_PULSE_MIN: pmin_r    <= cfg_wr.data[PULSE_BITS-1:0];
        REG_PULSE_MAX: pmax_r    <= cfg_wr.data[PULSE_BITS-1:0];
        REG_SLEW:      slew_r    <= cfg_wr.data[PULSE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign weights   = weights_r;
  assign trims     = trims_r;
  assign pulse_min = pmin_r;
  assign pulse_max = pmax_r;
  assign slew_step = slew_r;

endmodule

### rtl/qxm_div.sv
module qxm_div #(
  parameter int PULSE_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [PULSE_BITS-1:0]     num,
  input  logic [PULSE_BITS-1:0]     den,
  output logic                      done,
  output logic [qxm_pkg::QUOT_W-1:0] quot
);
  import qxm_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  // restoring division of (num << QUOT_W) by den, num < den
  logic [PULSE_BITS-1:0] rem_r;
  logic [QUOT_W-1:0]     quot_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [PULSE_BITS:0]   shifted;
  logic [PULSE_BITS:0]   diff;
  logic                  ge;
  logic                  last;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};
  assign last    = cnt_r == CNT_W'(QUOT_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[PULSE_BITS-1:0] : shifted[PULSE_BITS-1:0];
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### rtl/qxm_lane.sv
module qxm_lane #(
  parameter int PULSE_BITS = 12
) (
  input  logic                              clk,
  input  qxm_pkg::qxm_lane_ctl_t            ctl,
  input  logic [qxm_pkg::THR_W-1:0]         thr,
  input  logic signed [qxm_pkg::CTRL_W-1:0] ctrl,
  input  logic [qxm_pkg::WEIGHT_W-1:0]      weight,
  input  logic signed [qxm_pkg::TRIM_W-1:0] trim,
  input  logic [qxm_pkg::SCALE_W-1:0]       scale,
  input  logic [PULSE_BITS-1:0]             prev,
  input  logic [PULSE_BITS-1:0]             slew_step,
  input  logic [PULSE_BITS-1:0]             pulse_min,
  input  logic [PULSE_BITS-1:0]             pulse_max,
  output logic [PULSE_BITS-1:0]             result
);
  import qxm_pkg::*;

  localparam int PW_W = CTRL_W + WEIGHT_W + 1;
  localparam int PT_W = TRIM_W + SCALE_W + 1;

  logic signed [PW_W-1:0]    prod_w_r;
  logic signed [PT_W-1:0]    prod_t_r;
  logic signed [TGT_W-1:0]   target_r;
  logic signed [TGT_W-1:0]   target_nxt;

  logic signed [TOTAL_W-1:0] w_ext;
  logic signed [TOTAL_W-1:0] t_ext;
  logic signed [TOTAL_W-1:0] thr_ext;
  logic signed [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0]        mag;
  logic [TOTAL_W-1:0]        rnd;
  logic [TGT_W-1:0]          tgt_mag;
  logic                      neg;

  logic signed [TGT_W-1:0]   prev_x;
  logic signed [TGT_W-1:0]   step_x;
  logic signed [TGT_W-1:0]   min_x;
  logic signed [TGT_W-1:0]   max_x;
  logic signed [TGT_W-1:0]   win_lo;
  logic signed [TGT_W-1:0]   win_hi;
  logic signed [TGT_W-1:0]   slewed;
  logic signed [TGT_W-1:0]   bounded;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_w_r <= ctrl * $signed({1'b0, weight});
      prod_t_r <= trim * $signed({1'b0, scale});
    end
    if (ctl.sum_en) begin
      target_r <= target_nxt;
    end
  end

  // total in units of 2^-18 us, then round half away from zero
  always_comb begin
    w_ext   = TOTAL_W'(prod_w_r);
    t_ext   = TOTAL_W'(prod_t_r) <<< 2;
    thr_ext = $signed({{(TOTAL_W - THR_W - ROUND_SHIFT){1'b0}}, thr,
                       {ROUND_SHIFT{1'b0}}});
    total   = w_ext + t_ext + thr_ext;
    neg     = total[TOTAL_W-1];
    mag     = neg ? TOTAL_W'(-total) : TOTAL_W'(total);
    rnd     = (mag + (TOTAL_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    tgt_mag = rnd[TGT_W-1:0];
    target_nxt = neg ? -$signed(tgt_mag) : $signed(tgt_mag);
  end

  always_comb begin
    prev_x = $signed(TGT_W'(prev));
    step_x = $signed(TGT_W'(slew_step));
    min_x  = $signed(TGT_W'(pulse_min));
    max_x  = $signed(TGT_W'(pulse_max));
    win_lo = prev_x - step_x;
    win_hi = prev_x + step_x;

    priority if (target_r < win_lo) begin
      slewed = win_lo;
    end else if (target_r > win_hi) begin
      slewed = win_hi;
    end else begin
      slewed = target_r;
    end

    priority if (slewed < min_x) begin
      bounded = min_x;
    end else if (slewed > max_x) begin
      bounded = max_x;
    end else begin
      bounded = slewed;
    end

    result = bounded[PULSE_BITS-1:0];
  end

endmodule

### rtl/quad_x_motor_mixer_slew.sv
// A mix request that needs the trim fade division runs the 16-step serial
// divider, then the lane; with a fade of 0 or 1.0 it goes to the lane at once,
// and a history reset request goes straight to the result. One request at a
// time: the next is taken once the last result is loaded, which waits on a
// stalled output. The four motors share one multiply / round / slew-clamp lane.
// Synchronous active-low reset: registers to defaults, history to 1000.
module quad_x_motor_mixer_slew #(
  parameter int PULSE_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  qxm_in_if.sink    in_req,
  qxm_out_if.source out_res,
  qxm_cfg_if.sink   cfg_wr
);
  import qxm_pkg::*;

  localparam int CMP_W = (PULSE_BITS > THR_W) ? PULSE_BITS : THR_W;

  logic [CFG_DATA_W-1:0] weights;
  logic [CFG_DATA_W-1:0] trims;
  logic [PULSE_BITS-1:0] pulse_min;
  logic [PULSE_BITS-1:0] pulse_max;
  logic [PULSE_BITS-1:0] slew_step;

  qxm_state_t state_r;
  qxm_state_t state_nxt;

  logic [MOTOR_IDX_W-1:0]   motor_r;
  logic [THR_W-1:0]         thr_r;
  logic signed [CORR_W-1:0] pitch_r;
  logic signed [CORR_W-1:0] roll_r;
  logic signed [CORR_W-1:0] yaw_r;
  logic [SCALE_W-1:0]       scale_r;
  logic [PULSE_BITS-1:0]    prev_r [MOTOR_COUNT];

  logic                     out_valid_r;
  logic [PULSE_BITS-1:0]    out_fl_r;
  logic [PULSE_BITS-1:0]    out_fr_r;
  logic [PULSE_BITS-1:0]    out_rl_r;
  logic [PULSE_BITS-1:0]    out_rr_r;

  logic                     accept;
  logic                     is_reset;
  logic [CMP_W-1:0]         thr_x;
  logic [CMP_W-1:0]         hi_x;
  logic [CMP_W-1:0]         lo_x;
  logic                     no_trim;
  logic                     full_trim;
  logic                     need_div;
  logic [PULSE_BITS-1:0]    div_num;
  logic [PULSE_BITS-1:0]    div_den;
  logic                     div_start;
  logic                     div_done;
  logic [QUOT_W-1:0]        div_quot;

  logic signed [CTRL_W-1:0] p_x;
  logic signed [CTRL_W-1:0] r_x;
  logic signed [CTRL_W-1:0] y_x;
  logic signed [CTRL_W-1:0] ctrl;
  logic [WEIGHT_W-1:0]      weight;
  logic signed [TRIM_W-1:0] trim;
  logic [PULSE_BITS-1:0]    lane_res;
  qxm_lane_ctl_t            lane_ctl;
  logic                     prev_we;
  logic                     out_load;
  logic                     last_motor;

  qxm_cfg_regs #(.PULSE_BITS(PULSE_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .weights   (weights),
    .trims     (trims),
    .pulse_min (pulse_min),
    .pulse_max (pulse_max),
    .slew_step (slew_step)
  );

  assign accept   = in_req.valid && in_req.ready;
  assign is_reset = in_req.kind;

  // trim fade: 0 at or above pulse_max or with an empty range, 1.0 at or below pulse_min
  always_comb begin
    thr_x     = CMP_W'(in_req.throttle_us);
    hi_x      = CMP_W'(pulse_max);
    lo_x      = CMP_W'(pulse_min);
    no_trim   = (hi_x <= lo_x) || (thr_x >= hi_x);
    full_trim = thr_x <= lo_x;
    need_div  = !no_trim && !full_trim;
    div_num   = PULSE_BITS'(hi_x - thr_x);
    div_den   = pulse_max - pulse_min;
  end

  qxm_div #(.PULSE_BITS(PULSE_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    p_x    = NEG_PITCH[motor_r] ? -CTRL_W'(pitch_r) : CTRL_W'(pitch_r);
    r_x    = NEG_ROLL[motor_r]  ? -CTRL_W'(roll_r)  : CTRL_W'(roll_r);
    y_x    = NEG_YAW[motor_r]   ? -CTRL_W'(yaw_r)   : CTRL_W'(yaw_r);
    ctrl   = p_x + r_x + y_x;
    weight = weights[motor_r * WEIGHT_W +: WEIGHT_W];
    trim   = $signed(trims[motor_r * TRIM_W +: TRIM_W]);
  end

  qxm_lane #(.PULSE_BITS(PULSE_BITS)) u_lane (
    .clk       (clk),
    .ctl       (lane_ctl),
    .thr       (thr_r),
    .ctrl      (ctrl),
    .weight    (weight),
    .trim      (trim),
    .scale     (scale_r),
    .prev      (prev_r[motor_r]),
    .slew_step (slew_step),
    .pulse_min (pulse_min),
    .pulse_max (pulse_max),
    .result    (lane_res)
  );

  assign last_motor = motor_r == MOTOR_IDX_W'(MOTOR_COUNT - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (is_reset) begin
            state_nxt = ST_FIN;
          end else if (need_div) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = last_motor ? ST_FIN : ST_MUL;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_req.ready    = state_r == ST_IDLE;
    div_start       = accept && !is_reset && need_div;
    lane_ctl.mul_en = state_r == ST_MUL;
    lane_ctl.sum_en = state_r == ST_SUM;
    prev_we         = state_r == ST_CLAMP;
    out_load        = (state_r == ST_FIN) && (!out_valid_r || out_res.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      motor_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        prev_r[i] <= PULSE_BITS'(PULSE_MIN_RST);
      end
    end else begin
      state_r <= state_nxt;
      if (prev_we) begin
        prev_r[motor_r] <= lane_res;
        motor_r         <= last_motor ? '0 : motor_r + 1'b1;
      end else if (accept && is_reset) begin
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          prev_r[i] <= pulse_min;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      thr_r   <= in_req.throttle_us;
      pitch_r <= in_req.pitch_corr;
      roll_r  <= in_req.roll_corr;
      yaw_r   <= in_req.yaw_corr;
      if (no_trim) begin
        scale_r <= '0;
      end else if (full_trim) begin
        scale_r <= SCALE_ONE;
      end
    end else if (state_r == ST_DIV && div_done) begin
      scale_r <= {1'b0, div_quot};
    end
    if (out_load) begin
      out_fl_r <= prev_r[0];
      out_fr_r <= prev_r[1];
      out_rl_r <= prev_r[2];
      out_rr_r <= prev_r[3];
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.front_left_us  = out_fl_r;
  assign out_res.front_right_us = out_fr_r;
  assign out_res.rear_left_us   = out_rl_r;
  assign out_res.rear_right_us  = out_rr_r;

endmodule
